// ===== hw/rtl/rbsc_pkg.sv =====
// Shared types and constants for the rank-by-smaller-count block.
// Used by rbsc_cell and rank_by_smaller_count; depends on nothing else.
package rbsc_pkg;

   localparam int unsigned MAX_ITEMS_DEF = 64;
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned RANK_W        = 6;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic        [RANK_W-1:0]  rank_type;

   // Operating phase of the block.
   typedef enum logic [1:0] {
      PH_FILL  = 2'b01,
      PH_DRAIN = 2'b10
   } phase_type;

   // Control broadcast along the row of cells.
   typedef struct packed {
      logic      insert;  // a new value is being stored this cycle
      logic      shift;   // head cell leaves, every cell takes its neighbor
      value_type key;     // value all cells compare against
   } cell_ctl_type;

endpackage

// ===== hw/rtl/rbsc_cell.sv =====
// One cell of the ranking chain: holds a stored value and its running count
// of smaller values. Depends on rbsc_pkg.
module rbsc_cell
   import rbsc_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         sel,
   input  value_type    nxt_value,
   input  rank_type     nxt_count,
   output value_type    value,
   output rank_type     count,
   output rank_type     count_fwd
);

   value_type value_ff, value_in;
   rank_type  count_ff, count_in;
   logic      key_smaller;

   assign key_smaller = ctl.key < value_ff;
   // Count as handed to the left neighbor on a shift, or kept on an insert.
   assign count_fwd   = count_ff + RANK_W'(key_smaller);

   always_comb begin
      value_in = value_ff;
      count_in = count_ff;
      if (ctl.shift) begin
         value_in = nxt_value;
         count_in = nxt_count;
      end else if (ctl.insert) begin
         if (sel) begin
            value_in = ctl.key;
            count_in = '0;
         end else begin
            count_in = count_fwd;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      count_ff <= count_in;
   end

   assign value = value_ff;
   assign count = count_ff;

endmodule

// ===== hw/rtl/rank_by_smaller_count.sv =====
// Top level of the rank-by-smaller-count block: control and the row of cells.
// Depends on rbsc_pkg and rbsc_cell.

// Collects a set of signed 32-bit values, one per req_ transaction, up to
// MAX_ITEMS of them, then returns each stored value's rank (number of stored
// values strictly smaller) in arrival order, one rsp_ transaction per value.
// A value arriving while the store is full is dropped and rsp_overflowed is
// set on every rank of that set. Values are taken one per cycle while the set
// is filling; each new value is compared in every cell at once. After the
// value marked last, req_stall stays high while the n ranks leave the head of
// the chain at one per cycle unless rsp_stall holds them (the chain shifts by
// one cell per rank).
// No clearing pass is needed after reset.
module rank_by_smaller_count
   import rbsc_pkg::*;
#(
   parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic        [RANK_W-1:0]  rsp_rank,
   output logic                      rsp_final_res,
   output logic                      rsp_overflowed
);

   localparam int unsigned FILL_W = $clog2(MAX_ITEMS + 1);
   localparam int unsigned IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

   phase_type          phase_ff, phase_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               ovf_ff, ovf_in;
   logic               req_take, rsp_take, full;
   cell_ctl_type       ctl;

   value_type cell_value [MAX_ITEMS];
   rank_type  cell_count [MAX_ITEMS];
   rank_type  cell_fwd   [MAX_ITEMS];

   assign req_stall = (phase_ff == PH_DRAIN);
   assign rsp_valid = (phase_ff == PH_DRAIN);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign full      = (fill_ff == FILL_W'(MAX_ITEMS));

   assign ctl.insert = req_take && !full;
   assign ctl.shift  = rsp_take;
   assign ctl.key    = (phase_ff == PH_DRAIN) ? cell_value[0] : req_value;

   for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
      value_type nxt_value;
      rank_type  nxt_count;
      if (g == MAX_ITEMS - 1) begin : g_tail
         assign nxt_value = '0;
         assign nxt_count = '0;
      end else begin : g_link
         assign nxt_value = cell_value[g+1];
         assign nxt_count = cell_fwd[g+1];
      end
      rbsc_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .sel       (fill_ff[IDX_W-1:0] == IDX_W'(g)),
         .nxt_value (nxt_value),
         .nxt_count (nxt_count),
         .value     (cell_value[g]),
         .count     (cell_count[g]),
         .count_fwd (cell_fwd[g])
      );
   end

   always_comb begin
      phase_in = phase_ff;
      fill_in  = fill_ff;
      ovf_in   = ovf_ff;
      unique case (phase_ff)
         PH_FILL: begin
            if (req_take) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               if (req_last) begin
                  phase_in = PH_DRAIN;
               end
            end
         end
         PH_DRAIN: begin
            if (rsp_take) begin
               fill_in = fill_ff - FILL_W'(1);
               // Leave drain after the final rank; start the next set clean.
               if (fill_ff == FILL_W'(1)) begin
                  phase_in = PH_FILL;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            phase_in = PH_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FILL;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp_rank       = cell_count[0];
   assign rsp_final_res  = (fill_ff == FILL_W'(1));
   assign rsp_overflowed = ovf_ff;

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DRAIN) |-> (fill_ff != '0))
      else $error("drain phase with empty store");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_ITEMS))
      else $error("fill count beyond capacity");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_last) |=> (phase_ff == PH_DRAIN))
      else $error("last value did not start the rank run");

   a_run_ends_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_final_res) |=>
         (phase_ff == PH_FILL && fill_ff == '0 && !ovf_ff))
      else $error("state not cleared after final rank");

endmodule

// ===== test/rank_by_smaller_count_tb.sv =====
// Testbench for rank_by_smaller_count: streams sets of signed values, predicts
// each set's ranks in arrival order and checks every rank transaction.
// Depends on rbsc_pkg and the rank_by_smaller_count RTL.
`timescale 1ns / 100ps

module rank_by_smaller_count_tb;
   import rbsc_pkg::*;

   localparam int        CAPACITY     = MAX_ITEMS_DEF;
   localparam int        RANDOM_ITEMS = 450;
   localparam int        IDLE_LIMIT   = 2000;
   localparam int        TAIL_CYCLES  = 2 * CAPACITY + 40;
   localparam value_type VALUE_MIN    = 32'sh8000_0000;
   localparam value_type VALUE_MAX    = 32'sh7FFF_FFFF;

   typedef struct packed {
      rank_type rank;
      logic     final_res;
      logic     overflowed;
   } rank_entry_type;

   // Keeps the set being collected and the ranks still owed by the block.
   class rank_scoreboard_type;
      value_type      held[$];
      logic           dropped;
      rank_entry_type expected_ranks[$];
      int             errors;

      function new();
         dropped = 1'b0;
         errors  = 0;
      endfunction

      function void note_value(value_type v, logic last);
         int             cnt;
         rank_entry_type e;
         if (held.size() < CAPACITY) begin
            held.push_back(v);
         end else begin
            dropped = 1'b1;
         end
         if (last) begin
            foreach (held[i]) begin
               cnt = 0;
               foreach (held[j]) begin
                  if (held[j] < held[i]) cnt++;
               end
               e.rank       = rank_type'(cnt);
               e.final_res  = (i == held.size() - 1);
               e.overflowed = dropped;
               expected_ranks.push_back(e);
            end
            held.delete();
            dropped = 1'b0;
         end
      endfunction

      function void check_rank(rank_type rank, logic final_res, logic overflowed);
         rank_entry_type e;
         if (expected_ranks.size() == 0) begin
            $error("unexpected rank transaction: rank=%0d final_res=%0b overflowed=%0b",
                   rank, final_res, overflowed);
            errors++;
         end else begin
            e = expected_ranks.pop_front();
            if (rank !== e.rank) begin
               $error("rank: expected %0d, actual %0d", e.rank, rank);
               errors++;
            end
            if (final_res !== e.final_res) begin
               $error("final_res: expected %0b, actual %0b", e.final_res, final_res);
               errors++;
            end
            if (overflowed !== e.overflowed) begin
               $error("overflowed: expected %0b, actual %0b", e.overflowed, overflowed);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_ranks.size();
      endfunction
   endclass

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   value_type req_value = '0;
   logic      req_last  = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   rank_type  rsp_rank;
   logic      rsp_final_res;
   logic      rsp_overflowed;

   int                  idle_cycles = 0;
   rank_scoreboard_type rank_board;

   rank_by_smaller_count #(
      .MAX_ITEMS(CAPACITY)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rank      (rsp_rank),
      .rsp_final_res (rsp_final_res),
      .rsp_overflowed(rsp_overflowed)
   );

   always #2 clock = ~clock;

   // Mostly no gap, sometimes a short one, rarely a long pause.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(25, 60);
   endfunction

   // Mix extremes, a narrow band around zero for ties, and full-range values.
   function automatic value_type random_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2, 3:    return value_type'(int'($urandom_range(0, 8)) - 4);
         4:       return VALUE_MIN + value_type'($urandom_range(0, 3));
         5:       return VALUE_MAX - value_type'($urandom_range(0, 3));
         default: return value_type'($urandom());
      endcase
   endfunction

   function automatic int random_set_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(1, 8);
      else if (r < 88) return $urandom_range(9, 40);
      else return $urandom_range(60, 72);
   endfunction

   // Hold the transaction until the block takes it; keep valid high across
   // back-to-back transactions.
   task automatic send_value(input value_type v, input logic last, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic send_set(input value_type vals[$], input bit burst);
      foreach (vals[k]) begin
         send_value(vals[k], k == vals.size() - 1, burst ? 0 : idle_length());
      end
   endtask

   task automatic wait_for_ranks();
      req_valid <= 1'b0;
      do @(posedge clock); while (rank_board.pending() != 0);
   endtask

   // Response side: open stretches broken by stalls, now and then a long
   // stretch with no stall at all.
   initial begin
      int open_len;
      int hold_len;
      forever begin
         open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 10);
         hold_len = idle_length();
         rsp_stall <= 1'b0;
         repeat (open_len) @(posedge clock);
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) rank_board.note_value(req_value, req_last);
         if (rsp_valid && !rsp_stall) begin
            rank_board.check_rank(rsp_rank, rsp_final_res, rsp_overflowed);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      do @(posedge clock); while (idle_cycles < IDLE_LIMIT);
      $error("no transaction for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      value_type set_vals[$];
      int        set_size;
      int        set_idx;
      int        stored_items;
      bit        burst;

      rank_board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: single-value set, extremes, ties, descending order.
      set_vals = '{VALUE_MIN};
      send_set(set_vals, 1'b0);
      set_vals = '{VALUE_MAX, VALUE_MIN, value_type'(0), value_type'(-1), value_type'(1)};
      send_set(set_vals, 1'b1);
      set_vals = '{value_type'(5), value_type'(5), value_type'(5), value_type'(-5),
                   value_type'(5)};
      send_set(set_vals, 1'b0);
      set_vals = '{VALUE_MAX, VALUE_MAX};
      send_set(set_vals, 1'b1);
      set_vals = '{value_type'(3), value_type'(2), value_type'(1), value_type'(0),
                   value_type'(-1), value_type'(-2), value_type'(-3)};
      send_set(set_vals, 1'b0);

      // Random sets; open with a full store, then overflow with the last value
      // dropped, then several dropped values.
      set_idx      = 0;
      stored_items = 0;
      while (stored_items < RANDOM_ITEMS) begin
         case (set_idx)
            0:       set_size = CAPACITY;
            1:       set_size = CAPACITY + 1;
            2:       set_size = CAPACITY + 6;
            default: set_size = random_set_size();
         endcase
         set_vals.delete();
         repeat (set_size) set_vals.push_back(random_value());
         burst = ($urandom_range(0, 4) == 0);
         send_set(set_vals, burst);
         stored_items += (set_size < CAPACITY) ? set_size : CAPACITY;
         if (set_idx == 3 || $urandom_range(0, 7) == 0) wait_for_ranks();
         set_idx++;
      end

      wait_for_ranks();
      // Catch any stray rank transaction after the last expected one.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (rank_board.errors == 0 && rank_board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
